FILE: hw/rtl/isl_pkg.sv
package isl_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WORD_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int CAP_W = 5;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD_AT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_LAST    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_AT      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PUSH_FIRST  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_UP   = 2'd1;
  localparam logic [1:0] SH_DOWN = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] value_out;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

FILE: hw/rtl/isl_controller.sv
module isl_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output isl_pkg::ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready  = (state == S_IDLE) || ((state == S_HOLD) && m_tready);
  assign m_tvalid  = (state == S_HOLD);
  assign ctrl.load = s_tvalid && s_tready;
  assign ctrl.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_HOLD;
      S_HOLD: begin
        // overlap: take the next item as the result leaves
        if (m_tready) state_next = s_tvalid ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: hw/rtl/isl_datapath.sv
module isl_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  isl_pkg::ctrl_t              ctrl,
  input  logic [isl_pkg::CMD_W-1:0]   cmd,
  input  logic [isl_pkg::POS_W-1:0]   position,
  input  logic [isl_pkg::WORD_W-1:0]  value_in,
  input  logic                        cfg_we,
  input  logic [isl_pkg::CAP_W-1:0]   cfg_data,
  output isl_pkg::res_t               res
);

  localparam int DEPTH = isl_pkg::DEPTH;
  localparam int CNT_W = isl_pkg::CNT_W;
  localparam int WORD_W = isl_pkg::WORD_W;

  logic [isl_pkg::CMD_W-1:0]  cmd_q;
  logic [isl_pkg::POS_W-1:0]  pos_q;
  logic [WORD_W-1:0]          word_q;
  logic [isl_pkg::CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]           count;
  logic [WORD_W-1:0]          slots [DEPTH];
  logic [WORD_W-1:0]          slots_next [DEPTH];

  logic [CNT_W-1:0]           cap_eff;
  logic [CNT_W-1:0]           cnt_m1;
  logic [CNT_W-1:0]           cnt_next;
  logic                       full;
  logic                       pos_in;
  logic [isl_pkg::STAT_W-1:0] status;
  logic [WORD_W-1:0]          rd;
  logic [1:0]                 shift;
  logic [CNT_W-1:0]           sh_pos;
  logic [CNT_W-1:0]           sh_lim;
  logic [CNT_W:0]             pos_ext;
  logic [CNT_W:0]             cnt_ext;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd;
      pos_q  <= position;
      word_q <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)         capacity <= isl_pkg::CAP_W'(DEPTH);
    else if (cfg_we) capacity <= cfg_data;
  end

  always_comb begin
    if (capacity == '0)
      cap_eff = CNT_W'(1);
    else if ({1'b0, capacity} > (isl_pkg::CAP_W + 1)'(DEPTH))
      cap_eff = CNT_W'(DEPTH);
    else
      cap_eff = CNT_W'(capacity);
  end

  assign full    = (count >= cap_eff);
  assign cnt_m1  = count - CNT_W'(1);
  assign pos_ext = (CNT_W + 1)'(pos_q);
  assign cnt_ext = {1'b0, count};
  assign pos_in  = (pos_ext < cnt_ext);

  always_comb begin
    status   = isl_pkg::ST_OK;
    rd       = '0;
    cnt_next = count;
    shift    = isl_pkg::SH_NONE;
    sh_pos   = '0;
    sh_lim   = count;
    unique case (cmd_q)
      isl_pkg::CMD_ADD_AT: begin
        if (full) status = isl_pkg::ST_FULL;
        else if (pos_ext > cnt_ext) status = isl_pkg::ST_BAD_INDEX;
        else begin
          shift    = isl_pkg::SH_UP;
          sh_pos   = CNT_W'(pos_q);
          cnt_next = count + CNT_W'(1);
        end
      end
      isl_pkg::CMD_ADD_LAST: begin
        if (full) status = isl_pkg::ST_FULL;
        else begin
          shift    = isl_pkg::SH_UP;
          sh_pos   = count;
          cnt_next = count + CNT_W'(1);
        end
      end
      isl_pkg::CMD_REMOVE_AT: begin
        if (count == '0) status = isl_pkg::ST_EMPTY;
        else if (!pos_in) status = isl_pkg::ST_BAD_INDEX;
        else begin
          shift    = isl_pkg::SH_DOWN;
          sh_pos   = CNT_W'(pos_q);
          sh_lim   = cnt_m1;
          cnt_next = cnt_m1;
        end
      end
      isl_pkg::CMD_REMOVE_LAST: begin
        if (count == '0) status = isl_pkg::ST_EMPTY;
        else begin
          shift    = isl_pkg::SH_DOWN;
          sh_pos   = cnt_m1;
          sh_lim   = cnt_m1;
          cnt_next = cnt_m1;
        end
      end
      isl_pkg::CMD_GET_AT: begin
        if (!pos_in) status = isl_pkg::ST_BAD_INDEX;
        else rd = slots[pos_q[isl_pkg::IDX_W-1:0]];
      end
      isl_pkg::CMD_PUSH_FIRST: begin
        if (full) begin
          if (cnt_m1 >= cap_eff) begin
            // still full after dropping the tail: drop only
            status   = isl_pkg::ST_FULL;
            shift    = isl_pkg::SH_DOWN;
            sh_pos   = cnt_m1;
            sh_lim   = cnt_m1;
            cnt_next = cnt_m1;
          end else begin
            // drop the tail and insert at the front in one shift
            shift  = isl_pkg::SH_UP;
            sh_lim = cnt_m1;
          end
        end else begin
          shift    = isl_pkg::SH_UP;
          cnt_next = count + CNT_W'(1);
        end
      end
      isl_pkg::CMD_CLEAR: cnt_next = '0;
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_src;
    logic [WORD_W-1:0] dn_src;
    if (i > 0) begin : g_up
      assign up_src = slots[i-1];
    end else begin : g_up0
      assign up_src = '0;
    end
    if (i < DEPTH - 1) begin : g_dn
      assign dn_src = slots[i+1];
    end else begin : g_dn0
      assign dn_src = '0;
    end

    always_comb begin
      slots_next[i] = slots[i];
      case (shift)
        isl_pkg::SH_UP: begin
          if (CNT_W'(i) == sh_pos) slots_next[i] = word_q;
          else if ((CNT_W'(i) > sh_pos) && (CNT_W'(i) <= sh_lim)) slots_next[i] = up_src;
        end
        isl_pkg::SH_DOWN: begin
          if (CNT_W'(i) == sh_lim) slots_next[i] = '0;
          else if ((CNT_W'(i) >= sh_pos) && (CNT_W'(i) < sh_lim)) slots_next[i] = dn_src;
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (ctrl.exec) slots[i] <= slots_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)            count <= '0;
    else if (ctrl.exec) count <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res.status    <= status;
      res.value_out <= rd;
      res.count     <= cnt_next;
      res.is_full   <= (cnt_next >= cap_eff);
      res.is_empty  <= (cnt_next == '0);
    end
  end

endmodule

FILE: hw/rtl/indexed_shift_list_top.sv
// Bounded list of up to 16 signed 32-bit words held in register cells. Each
// item carries one command and returns one result item. From acceptance to
// result the command is first captured, then the cells in the affected range
// move toward their neighbors at once; the next item is accepted in the cycle
// its predecessor's result is taken. Capacity is written through the cfg
// channel (always ready); the user must write it only while the block is
// idle, which the block itself does not enforce. 0 acts as 1 and values
// above 16 as 16. No clearing pass is needed after reset.
module indexed_shift_list_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[2:0], position[7:3], value_in[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[1:0], value_out[33:2], count[38:34],
                                 // is_full[39], is_empty[40], zero[47:41]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // capacity
);

  isl_pkg::ctrl_t ctrl;
  isl_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  isl_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  isl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd      (s_tdata[2:0]),
    .position (s_tdata[7:3]),
    .value_in (s_tdata[39:8]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  assign m_tdata = {7'd0, res};

  // no new item while an untaken result is still held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
    else $error("item accepted over a held result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, res.count} <= (isl_pkg::CNT_W + 1)'(isl_pkg::DEPTH)))
    else $error("count above depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.is_full && res.is_empty))
    else $error("list both full and empty");

  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.status != isl_pkg::ST_OK)) |-> (res.value_out == '0))
    else $error("word returned on a failed command");

endmodule

FILE: dv/indexed_shift_list_checker.sv
`timescale 1ns / 100ps

module indexed_shift_list_checker import isl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[2:0], position[7:3], value_in[39:8]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // status[1:0], value_out[33:2], count[38:34],
                                 // is_full[39], is_empty[40], zero[47:41]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,  // capacity
  output int          mismatch_count,
  output int          results_owed
);

  logic [WORD_W-1:0] cells [DEPTH];
  int                fill;
  logic [CAP_W-1:0]  cap_reg;
  res_t              owed_q [$];

  // saturate the register into 1..DEPTH
  function automatic int cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic logic [STAT_W-1:0] insert_word(int pos, logic [WORD_W-1:0] word);
    int i;
    if (fill >= cap_limit()) return ST_FULL;
    if (pos > fill) return ST_BAD_INDEX;
    for (i = fill; i > pos; i--) begin
      if (i < DEPTH) cells[i] = cells[i-1];
    end
    if (pos < DEPTH) cells[pos] = word;
    fill++;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] drop_word(int pos);
    int i;
    if (fill == 0) return ST_EMPTY;
    if (pos >= fill) return ST_BAD_INDEX;
    for (i = pos; i + 1 < fill; i++) begin
      if (i + 1 < DEPTH) cells[i] = cells[i+1];
    end
    // zero the vacated slot
    if (fill - 1 < DEPTH) cells[fill-1] = '0;
    fill--;
    return ST_OK;
  endfunction

  function automatic res_t apply_command(logic [39:0] item);
    logic [CMD_W-1:0]  op;
    int                pos;
    logic [WORD_W-1:0] word;
    res_t              r;
    op   = item[2:0];
    pos  = int'(item[7:3]);
    word = item[39:8];
    r    = '0;
    case (op)
      CMD_ADD_AT: r.status = insert_word(pos, word);
      CMD_ADD_LAST: r.status = insert_word(fill, word);
      CMD_REMOVE_AT: r.status = drop_word(pos);
      CMD_REMOVE_LAST: r.status = (fill == 0) ? ST_EMPTY : drop_word(fill - 1);
      CMD_GET_AT: begin
        if (pos >= fill || pos >= DEPTH) r.status = ST_BAD_INDEX;
        else r.value_out = cells[pos];
      end
      CMD_PUSH_FIRST: begin
        // on a full list drop the tail first; a lowered capacity may keep it full
        if (fill >= cap_limit()) begin
          r.status = (fill == 0) ? ST_EMPTY : drop_word(fill - 1);
          if (r.status == ST_OK) r.status = insert_word(0, word);
        end else begin
          r.status = insert_word(0, word);
        end
      end
      CMD_CLEAR: fill = 0;
      default: ;
    endcase
    r.count    = CNT_W'(fill);
    r.is_full  = (fill >= cap_limit());
    r.is_empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      fill         = 0;
      cap_reg      = CAP_W'(DEPTH);
      owed_q.delete();
      results_owed = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[40:0]);
        if (owed_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result item with nothing expected: status=%0d value=%0d count=%0d",
                     $realtime, got.status, $signed(got.value_out), got.count);
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          if (got.status !== want.status || got.value_out !== want.value_out ||
              got.count !== want.count || got.is_full !== want.is_full ||
              got.is_empty !== want.is_empty) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d value=%0d count=%0d full=%b empty=%b",
                       want.status, $signed(want.value_out), want.count,
                       want.is_full, want.is_empty);
              $display("  actual   status=%0d value=%0d count=%0d full=%b empty=%b",
                       got.status, $signed(got.value_out), got.count,
                       got.is_full, got.is_empty);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (s_tvalid && s_tready) owed_q.push_back(apply_command(s_tdata));
      results_owed = owed_q.size();
    end
  end

endmodule

FILE: dv/tb_indexed_shift_list_top.sv
`timescale 1ns / 100ps

module tb_indexed_shift_list_top;
  import isl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // cmd[2:0], position[7:3], value_in[39:8]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status[1:0], value_out[33:2], count[38:34],
                          // is_full[39], is_empty[40], zero[47:41]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;  // capacity

  int   mismatch_count;
  int   results_owed;
  int   send_idle = 0;
  int   recv_idle = 0;
  logic rx_hold   = 1'b0;
  int   cycles    = 0;

  indexed_shift_list_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  indexed_shift_list_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_indexed_shift_list_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || rx_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // leaves valid high after the handshake; the next call replaces or lowers it, drain lowers it
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {word, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_commands(input int n);
    int                k;
    int                roll;
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    for (k = 0; k < n; k++) begin
      // adds outweigh removes so the list fills up and churns near capacity
      roll = $urandom_range(0, 199);
      if (roll < 40) op = CMD_ADD_LAST;
      else if (roll < 70) op = CMD_ADD_AT;
      else if (roll < 100) op = CMD_PUSH_FIRST;
      else if (roll < 124) op = CMD_REMOVE_AT;
      else if (roll < 140) op = CMD_REMOVE_LAST;
      else if (roll < 192) op = CMD_GET_AT;
      else if (roll < 195) op = CMD_CLEAR;
      else op = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
      else pos = POS_W'($urandom_range(0, DEPTH));
      case ($urandom_range(0, 31))
        0: word = 32'h8000_0000;
        1: word = 32'h7FFF_FFFF;
        2: word = 32'h0000_0000;
        3: word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_item(op, pos, word);
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list, bad indexes, extremes of the word, unused code, clear
    send_item(CMD_REMOVE_LAST, 5'd0, 32'd0);
    send_item(CMD_REMOVE_AT, 5'd0, 32'd0);
    send_item(CMD_GET_AT, 5'd0, 32'd0);
    send_item(CMD_ADD_AT, 5'd1, 32'd5);
    send_item(CMD_ADD_LAST, 5'd0, 32'h7FFF_FFFF);
    send_item(CMD_ADD_AT, 5'd0, 32'h8000_0000);
    send_item(CMD_PUSH_FIRST, 5'd0, 32'hFFFF_FFFF);
    send_item(CMD_ADD_AT, 5'd3, 32'd0);
    send_item(CMD_GET_AT, 5'd31, 32'd0);
    send_item(CMD_GET_AT, 5'd2, 32'd0);
    send_item(CMD_REMOVE_AT, 5'd1, 32'd0);
    send_item(CMD_REMOVE_AT, 5'd16, 32'd0);
    send_item(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 5'd0, 32'd0);
    send_item(CMD_GET_AT, 5'd0, 32'd0);

    // full list, then push-first with the tail dropped
    set_capacity(5'd2);
    send_item(CMD_ADD_LAST, 5'd0, 32'd1);
    send_item(CMD_ADD_LAST, 5'd0, 32'd2);
    send_item(CMD_ADD_LAST, 5'd0, 32'd3);
    send_item(CMD_PUSH_FIRST, 5'd0, 32'd4);

    // capacity lowered below the count
    set_capacity(5'd1);
    send_item(CMD_PUSH_FIRST, 5'd0, 32'd5);
    send_item(CMD_ADD_AT, 5'd0, 32'd6);

    // zero capacity acts as one
    set_capacity(5'd0);
    send_item(CMD_REMOVE_LAST, 5'd0, 32'd0);
    send_item(CMD_ADD_LAST, 5'd0, 32'd7);
    send_item(CMD_PUSH_FIRST, 5'd0, 32'd8);

    send_idle = 23;
    recv_idle = 73;
    set_capacity(5'd31);
    random_commands(100);
    set_capacity(5'd3);
    random_commands(100);

    send_idle = 73;
    recv_idle = 23;
    set_capacity(5'd16);
    random_commands(100);
    set_capacity(5'd1);
    random_commands(100);

    send_idle = 0;
    recv_idle = 0;
    set_capacity(5'd9);
    // long receiver stall while items keep coming
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (80) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    random_commands(100);
    set_capacity(5'd16);
    random_commands(100);

    drain();
    if (mismatch_count == 0) begin
      $display("tb_indexed_shift_list_top: done, clean");
    end else begin
      $display("tb_indexed_shift_list_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/isl_pkg.sv
hw/rtl/isl_controller.sv
hw/rtl/isl_datapath.sv
hw/rtl/indexed_shift_list_top.sv
dv/indexed_shift_list_checker.sv
dv/tb_indexed_shift_list_top.sv
